// ===== hw/rtl/sdsr_pkg.sv =====
package sdsr_pkg;

    localparam int IMAGE_BLOCKS = 4;
    localparam int WAKE_BYTES   = 10;

    localparam int BLK_W  = $clog2(IMAGE_BLOCKS + 1);
    localparam int BYTE_W = 10;
    localparam int POLL_W = 28;
    localparam int TOK_W  = 24;
    localparam int LOOP_W = 16;
    localparam int SB_W   = 23;
    localparam int PH_W   = 5;

    localparam logic [1:0] ACT_INIT = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_BYTE = 2'd2;

    localparam logic [1:0] CFG_RESP_WAIT  = 2'd0;
    localparam logic [1:0] CFG_TOKEN_WAIT = 2'd1;
    localparam logic [1:0] CFG_INIT_RETRY = 2'd2;

    localparam logic [POLL_W-1:0] RESP_WAIT_RST  = 28'hFFFFFFF;
    localparam logic [TOK_W-1:0]  TOKEN_WAIT_RST = 24'hFFFFFF;
    localparam logic [LOOP_W-1:0] INIT_RETRY_RST = 16'hFFFE;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INIT_TMO = 2'd1;
    localparam logic [1:0] ST_TOK_TMO  = 2'd2;
    localparam logic [1:0] ST_REJECT   = 2'd3;

    localparam logic [1:0] K_RESET  = 2'd0;
    localparam logic [1:0] K_OPCOND = 2'd1;
    localparam logic [1:0] K_BLKLEN = 2'd2;
    localparam logic [1:0] K_READ   = 2'd3;

    localparam logic [PH_W-1:0] PH_IDLE  = 5'd0;
    localparam logic [PH_W-1:0] PH_WAKE  = 5'd1;
    localparam logic [PH_W-1:0] PH_GAP   = 5'd2;
    localparam logic [PH_W-1:0] PH_TOKEN = 5'd3;
    localparam logic [PH_W-1:0] PH_DATA  = 5'd4;
    localparam logic [PH_W-1:0] PH_TRAIL = 5'd5;

    localparam logic [2:0] GRP_SEND  = 3'b010;
    localparam logic [2:0] GRP_RESP  = 3'b011;
    localparam logic [2:0] GRP_EXTRA = 3'b100;

    localparam logic [7:0] BYTE_IDLE  = 8'hFF;
    localparam logic [7:0] BYTE_TOKEN = 8'hFE;
    localparam logic [7:0] BYTE_CRC   = 8'h95;
    localparam logic [7:0] R1_IDLE    = 8'h01;
    localparam logic [7:0] R1_READY   = 8'h00;
    localparam logic [7:0] CMD_BASE   = 8'h40;

    localparam logic [BYTE_W-1:0] BLOCK_BYTES = 10'd512;
    localparam logic [31:0]       BLOCK_ARG   = 32'd512;

    typedef struct packed {
        logic [PH_W-1:0]   phase;
        logic [BYTE_W-1:0] byte_cnt;
        logic [BLK_W-1:0]  block_cnt;
        logic [POLL_W-1:0] poll_cnt;
        logic [LOOP_W-1:0] loop_cnt;
        logic [31:0]       cmd_arg;
        logic              second_of_pair;
        logic [7:0]        held_resp;
        logic              cs_held;
    } t_state;

    typedef struct packed {
        logic [POLL_W-1:0] resp_wait;
        logic [TOK_W-1:0]  token_wait;
        logic [LOOP_W-1:0] init_retry;
    } t_cfg;

    typedef struct packed {
        logic [7:0] card_response;
        logic [1:0] status;
        logic       done_res;
        logic [7:0] data_byte;
        logic       chip_select;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       data_valid;
    } t_result;

    function automatic logic [7:0] opcode(input logic [1:0] k);
        logic [7:0] op;
        case (k)
            K_RESET:  op = CMD_BASE | 8'd0;
            K_OPCOND: op = CMD_BASE | 8'd1;
            K_BLKLEN: op = CMD_BASE | 8'd16;
            K_READ:   op = CMD_BASE | 8'd17;
            default:  op = CMD_BASE;
        endcase
        return op;
    endfunction

    function automatic logic [7:0] frame_byte(input logic [1:0] k, input logic [2:0] idx,
                                              input logic [31:0] arg);
        logic [7:0] b;
        case (idx)
            3'd0:    b = opcode(k);
            3'd1:    b = arg[31:24];
            3'd2:    b = arg[23:16];
            3'd3:    b = arg[15:8];
            3'd4:    b = arg[7:0];
            default: b = BYTE_CRC;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/sd_card_spi_init_and_image_read_top.sv =====
// Master-side sequencer for an SD card in SPI mode. Each input transaction reports the byte
// received in the previous SPI exchange (or starts an init or an image read), and each output
// transaction gives the byte to send next, chip select, an image byte when one arrived, and the
// done flag with status. One output transaction follows every input transaction, through an
// input register and a result register; a new input transaction is taken every cycle
// while the output side keeps up. The sequencer state lives in a single register set updated by
// the step logic, so throughput is bounded only by output back-pressure. Configuration writes are
// always ready and must occur only while no transaction is in flight.
module sd_card_spi_init_and_image_read_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [22:0] start_block, [30:23] rx_byte, [31] zero
    input  logic [31:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] tx_byte, [8] tx_valid, [9] chip_select, [17:10] data_byte, [18] done_res,
    // [20:19] status, [28:21] card_response, [31:29] zero
    output logic [31:0] m_axis_tdata,
    // [0] data_valid
    output logic        m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [27:0] i_cfg_data
);

    sdsr_pkg::t_state  r_state;
    sdsr_pkg::t_state  n_state;
    sdsr_pkg::t_cfg    r_cfg;
    sdsr_pkg::t_result n_res;
    sdsr_pkg::t_result r_res;

    logic                      r_in_valid;
    logic [1:0]                r_action;
    logic [sdsr_pkg::SB_W-1:0] r_start_block;
    logic [7:0]                r_rx_byte;
    logic                      r_out_valid;
    logic                      out_free;
    logic                      fire;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || fire;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_action      <= s_axis_tuser;
            r_start_block <= s_axis_tdata[22:0];
            r_rx_byte     <= s_axis_tdata[30:23];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.resp_wait  <= sdsr_pkg::RESP_WAIT_RST;
            r_cfg.token_wait <= sdsr_pkg::TOKEN_WAIT_RST;
            r_cfg.init_retry <= sdsr_pkg::INIT_RETRY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sdsr_pkg::CFG_RESP_WAIT:  r_cfg.resp_wait  <= i_cfg_data;
                sdsr_pkg::CFG_TOKEN_WAIT: r_cfg.token_wait <= i_cfg_data[23:0];
                sdsr_pkg::CFG_INIT_RETRY: r_cfg.init_retry <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    sdsr_step u_step (
        .i_state       (r_state),
        .i_cfg         (r_cfg),
        .i_action      (r_action),
        .i_start_block (r_start_block),
        .i_rx_byte     (r_rx_byte),
        .o_state       (n_state),
        .o_result      (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= sdsr_pkg::PH_IDLE;
            r_state.byte_cnt       <= '0;
            r_state.block_cnt      <= '0;
            r_state.poll_cnt       <= '0;
            r_state.loop_cnt       <= '0;
            r_state.cmd_arg        <= '0;
            r_state.second_of_pair <= 1'b0;
            r_state.held_resp      <= sdsr_pkg::BYTE_IDLE;
            r_state.cs_held        <= 1'b0;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_res.data_valid;
    assign m_axis_tdata  = {3'd0, r_res.card_response, r_res.status, r_res.done_res,
                            r_res.data_byte, r_res.chip_select, r_res.tx_valid, r_res.tx_byte};

`ifndef SYNTHESIS
    a_data_needs_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[8])
        else $error("image byte without a following exchange");

    a_done_stops_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[18] |-> !m_axis_tdata[8])
        else $error("done item still requests an exchange");

    a_status_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[18] |-> m_axis_tdata[20:19] == sdsr_pkg::ST_OK)
        else $error("nonzero status on an item that is not done");

    a_state_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_state))
        else $error("sequencer state changed without a processed item");
`endif

endmodule

// ===== hw/rtl/sdsr_step.sv =====
module sdsr_step (
    input  sdsr_pkg::t_state                 i_state,
    input  sdsr_pkg::t_cfg                   i_cfg,
    input  logic [1:0]                       i_action,
    input  logic [sdsr_pkg::SB_W-1:0]        i_start_block,
    input  logic [7:0]                       i_rx_byte,
    output sdsr_pkg::t_state                 o_state,
    output sdsr_pkg::t_result                o_result
);

    localparam int BLKW = sdsr_pkg::BLK_W;

    sdsr_pkg::t_state ns;
    logic             bg;
    logic [1:0]       bg_k;
    logic [31:0]      bg_arg;
    logic             fin;
    logic [1:0]       fin_st;
    logic             txv;
    logic [7:0]       tx;
    logic             dv;
    logic [7:0]       db;
    logic [1:0]       k;
    logic [BLKW-1:0]  blk_next;

    assign k        = i_state.phase[1:0];
    assign blk_next = i_state.block_cnt + BLKW'(1);

    always_comb begin
        ns     = i_state;
        bg     = 1'b0;
        bg_k   = sdsr_pkg::K_RESET;
        bg_arg = '0;
        fin    = 1'b0;
        fin_st = sdsr_pkg::ST_OK;
        txv    = 1'b0;
        tx     = 8'h00;
        dv     = 1'b0;
        db     = 8'h00;

        case (i_action)
            sdsr_pkg::ACT_INIT: begin
                ns.loop_cnt       = '0;
                ns.second_of_pair = 1'b0;
                ns.cs_held        = 1'b0;
                ns.phase          = sdsr_pkg::PH_WAKE;
                ns.byte_cnt       = 10'd1;
                txv               = 1'b1;
                tx                = sdsr_pkg::BYTE_IDLE;
            end
            sdsr_pkg::ACT_READ: begin
                ns.block_cnt = '0;
                bg           = 1'b1;
                bg_k         = sdsr_pkg::K_READ;
                bg_arg       = {i_start_block, 9'd0};
            end
            sdsr_pkg::ACT_BYTE: begin
                if (i_state.phase == sdsr_pkg::PH_WAKE) begin
                    if (i_state.byte_cnt < 10'(sdsr_pkg::WAKE_BYTES)) begin
                        ns.byte_cnt = i_state.byte_cnt + 10'd1;
                        txv         = 1'b1;
                        tx          = sdsr_pkg::BYTE_IDLE;
                    end else begin
                        ns.loop_cnt = '0;
                        bg          = 1'b1;
                        bg_k        = sdsr_pkg::K_RESET;
                    end
                end else if (i_state.phase == sdsr_pkg::PH_GAP) begin
                    if (i_state.byte_cnt < 10'd2) begin
                        ns.byte_cnt = i_state.byte_cnt + 10'd1;
                        txv         = 1'b1;
                        tx          = sdsr_pkg::BYTE_IDLE;
                    end else begin
                        ns.loop_cnt       = '0;
                        ns.second_of_pair = 1'b0;
                        bg                = 1'b1;
                        bg_k              = sdsr_pkg::K_OPCOND;
                    end
                end else if (i_state.phase[4:2] == sdsr_pkg::GRP_SEND) begin
                    txv = 1'b1;
                    if (i_state.byte_cnt < 10'd6) begin
                        tx = sdsr_pkg::frame_byte(k, i_state.byte_cnt[2:0], i_state.cmd_arg);
                        ns.byte_cnt = i_state.byte_cnt + 10'd1;
                    end else begin
                        tx          = sdsr_pkg::BYTE_IDLE;
                        ns.poll_cnt = '0;
                        ns.phase    = {sdsr_pkg::GRP_RESP, k};
                    end
                end else if (i_state.phase[4:2] == sdsr_pkg::GRP_RESP) begin
                    txv = 1'b1;
                    tx  = sdsr_pkg::BYTE_IDLE;
                    if (i_rx_byte == sdsr_pkg::BYTE_IDLE &&
                        i_state.poll_cnt < i_cfg.resp_wait) begin
                        ns.poll_cnt = i_state.poll_cnt + 28'd1;
                    end else begin
                        ns.held_resp = i_rx_byte;
                        ns.phase     = {sdsr_pkg::GRP_EXTRA, k};
                    end
                end else if (i_state.phase[4:2] == sdsr_pkg::GRP_EXTRA) begin
                    case (k)
                        sdsr_pkg::K_RESET: begin
                            if (i_state.held_resp == sdsr_pkg::R1_IDLE) begin
                                ns.cs_held  = 1'b0;
                                ns.phase    = sdsr_pkg::PH_GAP;
                                ns.byte_cnt = 10'd1;
                                txv         = 1'b1;
                                tx          = sdsr_pkg::BYTE_IDLE;
                            end else if (i_state.loop_cnt < i_cfg.init_retry) begin
                                ns.loop_cnt = i_state.loop_cnt + 16'd1;
                                bg          = 1'b1;
                                bg_k        = sdsr_pkg::K_RESET;
                            end else begin
                                fin    = 1'b1;
                                fin_st = sdsr_pkg::ST_INIT_TMO;
                            end
                        end
                        sdsr_pkg::K_OPCOND: begin
                            if (!i_state.second_of_pair) begin
                                ns.second_of_pair = 1'b1;
                                bg                = 1'b1;
                                bg_k              = sdsr_pkg::K_OPCOND;
                            end else begin
                                ns.second_of_pair = 1'b0;
                                if (i_state.held_resp == sdsr_pkg::R1_READY) begin
                                    bg     = 1'b1;
                                    bg_k   = sdsr_pkg::K_BLKLEN;
                                    bg_arg = sdsr_pkg::BLOCK_ARG;
                                end else if (i_state.loop_cnt < i_cfg.init_retry) begin
                                    ns.loop_cnt = i_state.loop_cnt + 16'd1;
                                    bg          = 1'b1;
                                    bg_k        = sdsr_pkg::K_OPCOND;
                                end else begin
                                    fin    = 1'b1;
                                    fin_st = sdsr_pkg::ST_INIT_TMO;
                                end
                            end
                        end
                        sdsr_pkg::K_BLKLEN: begin
                            ns.cs_held = 1'b0;
                            fin        = 1'b1;
                        end
                        default: begin
                            if (i_state.held_resp != sdsr_pkg::R1_READY) begin
                                fin    = 1'b1;
                                fin_st = sdsr_pkg::ST_REJECT;
                            end else begin
                                ns.phase    = sdsr_pkg::PH_TOKEN;
                                ns.poll_cnt = '0;
                                txv         = 1'b1;
                                tx          = sdsr_pkg::BYTE_IDLE;
                            end
                        end
                    endcase
                end else if (i_state.phase == sdsr_pkg::PH_TOKEN) begin
                    if (i_rx_byte == sdsr_pkg::BYTE_TOKEN) begin
                        ns.phase    = sdsr_pkg::PH_DATA;
                        ns.byte_cnt = '0;
                        txv         = 1'b1;
                        tx          = sdsr_pkg::BYTE_IDLE;
                    end else if (i_state.poll_cnt < {4'd0, i_cfg.token_wait}) begin
                        ns.poll_cnt = i_state.poll_cnt + 28'd1;
                        txv         = 1'b1;
                        tx          = sdsr_pkg::BYTE_IDLE;
                    end else begin
                        ns.cs_held = 1'b0;
                        fin        = 1'b1;
                        fin_st     = sdsr_pkg::ST_TOK_TMO;
                    end
                end else if (i_state.phase == sdsr_pkg::PH_DATA) begin
                    dv  = 1'b1;
                    db  = i_rx_byte;
                    txv = 1'b1;
                    tx  = sdsr_pkg::BYTE_IDLE;
                    if (i_state.byte_cnt + 10'd1 >= sdsr_pkg::BLOCK_BYTES) begin
                        ns.phase    = sdsr_pkg::PH_TRAIL;
                        ns.byte_cnt = '0;
                    end else begin
                        ns.byte_cnt = i_state.byte_cnt + 10'd1;
                    end
                end else if (i_state.phase == sdsr_pkg::PH_TRAIL) begin
                    ns.byte_cnt = i_state.byte_cnt + 10'd1;
                    if (i_state.byte_cnt + 10'd1 < 10'd3) begin
                        txv = 1'b1;
                        tx  = sdsr_pkg::BYTE_IDLE;
                    end else begin
                        ns.block_cnt = blk_next;
                        if (blk_next < BLKW'(sdsr_pkg::IMAGE_BLOCKS)) begin
                            bg     = 1'b1;
                            bg_k   = sdsr_pkg::K_READ;
                            bg_arg = i_state.cmd_arg + sdsr_pkg::BLOCK_ARG;
                        end else begin
                            ns.cs_held = 1'b0;
                            fin        = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (bg) begin
            ns.cmd_arg  = bg_arg;
            ns.phase    = {sdsr_pkg::GRP_SEND, bg_k};
            ns.byte_cnt = 10'd1;
            ns.cs_held  = 1'b1;
            txv         = 1'b1;
            tx          = sdsr_pkg::opcode(bg_k);
        end
        if (fin) begin
            ns.phase = sdsr_pkg::PH_IDLE;
        end
    end

    assign o_state                = ns;
    assign o_result.tx_byte       = tx;
    assign o_result.tx_valid      = txv;
    assign o_result.chip_select   = ns.cs_held;
    assign o_result.data_valid    = dv;
    assign o_result.data_byte     = db;
    assign o_result.done_res      = fin;
    assign o_result.status        = fin ? fin_st : sdsr_pkg::ST_OK;
    assign o_result.card_response = ns.held_resp;

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdsr_pkg::*;

    localparam logic [1:0]  ACT_UNUSED       = 2'd3;
    localparam logic [7:0]  OP_GO_IDLE       = 8'h40;
    localparam logic [7:0]  OP_SEND_OP_COND  = 8'h41;
    localparam logic [7:0]  OP_SET_BLOCKLEN  = 8'h50;
    localparam logic [7:0]  OP_READ_BLOCK    = 8'h51;
    localparam logic [27:0] RESP_WAIT_RESET  = 28'hFFFFFFF;
    localparam logic [23:0] TOKEN_WAIT_RESET = 24'hFFFFFF;
    localparam logic [15:0] INIT_RETRY_RESET = 16'hFFFE;
    localparam logic [27:0] CFG_FULL_SCALE   = 28'hFFFFFFF;
    localparam int FRAME_BYTES  = 6;
    localparam int GAP_BYTES    = 2;
    localparam int TRAIL_BYTES  = 3;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int QUIET_CYCLES = 8;

    class sd_seq_scoreboard;
        t_result     expected_q[$];
        logic [27:0] resp_limit;
        logic [23:0] token_limit;
        logic [15:0] retry_limit;
        logic [4:0]  phase;
        int          byte_cnt;
        int          block_cnt;
        logic [27:0] poll_cnt;
        logic [15:0] loop_cnt;
        logic [31:0] cmd_arg;
        logic        second_of_pair;
        logic [7:0]  held_resp;
        logic        cs_held;
        t_result     nxt;
        int          errors;
        int          n_inputs;
        int          n_results;
        int          n_image_bytes;
        int          n_done[4];

        function new();
            resp_limit     = RESP_WAIT_RESET;
            token_limit    = TOKEN_WAIT_RESET;
            retry_limit    = INIT_RETRY_RESET;
            phase          = PH_IDLE;
            byte_cnt       = 0;
            block_cnt      = 0;
            poll_cnt       = '0;
            loop_cnt       = '0;
            cmd_arg        = '0;
            second_of_pair = 1'b0;
            held_resp      = BYTE_IDLE;
            cs_held        = 1'b0;
            errors         = 0;
            n_inputs       = 0;
            n_results      = 0;
            n_image_bytes  = 0;
            n_done         = '{default: 0};
        endfunction

        function void write_cfg(logic [1:0] idx, logic [27:0] data);
            case (idx)
                CFG_RESP_WAIT:  resp_limit = data;
                CFG_TOKEN_WAIT: token_limit = data[23:0];
                CFG_INIT_RETRY: retry_limit = data[15:0];
                default: ;
            endcase
        endfunction

        function void transmit(logic [7:0] b);
            nxt.tx_byte  = b;
            nxt.tx_valid = 1'b1;
        endfunction

        function void conclude(logic [1:0] st);
            phase         = PH_IDLE;
            nxt.done_res  = 1'b1;
            nxt.status    = st;
        endfunction

        function logic [7:0] frame_byte(logic [1:0] k, int idx);
            logic [31:0] shifted;
            if (idx == 0) begin
                case (k)
                    K_RESET:  return OP_GO_IDLE;
                    K_OPCOND: return OP_SEND_OP_COND;
                    K_BLKLEN: return OP_SET_BLOCKLEN;
                    default:  return OP_READ_BLOCK;
                endcase
            end
            if (idx >= FRAME_BYTES - 1) return BYTE_CRC;
            shifted = cmd_arg >> (8 * (FRAME_BYTES - 2 - idx));
            return shifted[7:0];
        endfunction

        function void start_command(logic [1:0] k, logic [31:0] arg);
            cmd_arg  = arg;
            phase    = {GRP_SEND, k};
            byte_cnt = 1;
            cs_held  = 1'b1;
            transmit(frame_byte(k, 0));
        endfunction

        function void close_command(logic [1:0] k);
            if (k == K_RESET) begin
                if (held_resp == R1_IDLE) begin
                    cs_held  = 1'b0;
                    phase    = PH_GAP;
                    byte_cnt = 1;
                    transmit(BYTE_IDLE);
                end else if (loop_cnt < retry_limit) begin
                    loop_cnt = loop_cnt + 1'b1;
                    start_command(K_RESET, '0);
                end else begin
                    conclude(ST_INIT_TMO);
                end
            end else if (k == K_OPCOND) begin
                if (!second_of_pair) begin
                    second_of_pair = 1'b1;
                    start_command(K_OPCOND, '0);
                end else begin
                    second_of_pair = 1'b0;
                    if (held_resp == R1_READY) begin
                        start_command(K_BLKLEN, BLOCK_ARG);
                    end else if (loop_cnt < retry_limit) begin
                        loop_cnt = loop_cnt + 1'b1;
                        start_command(K_OPCOND, '0);
                    end else begin
                        conclude(ST_INIT_TMO);
                    end
                end
            end else if (k == K_BLKLEN) begin
                cs_held = 1'b0;
                conclude(ST_OK);
            end else if (held_resp != R1_READY) begin
                conclude(ST_REJECT);
            end else begin
                phase    = PH_TOKEN;
                poll_cnt = '0;
                transmit(BYTE_IDLE);
            end
        endfunction

        function void advance(logic [7:0] rx);
            logic [1:0] k;
            k = phase[1:0];
            if (phase == PH_WAKE) begin
                if (byte_cnt < WAKE_BYTES) begin
                    byte_cnt++;
                    transmit(BYTE_IDLE);
                end else begin
                    loop_cnt = '0;
                    start_command(K_RESET, '0);
                end
            end else if (phase == PH_GAP) begin
                if (byte_cnt < GAP_BYTES) begin
                    byte_cnt++;
                    transmit(BYTE_IDLE);
                end else begin
                    loop_cnt       = '0;
                    second_of_pair = 1'b0;
                    start_command(K_OPCOND, '0);
                end
            end else if (phase[4:2] == GRP_SEND) begin
                if (byte_cnt < FRAME_BYTES) begin
                    transmit(frame_byte(k, byte_cnt));
                    byte_cnt++;
                end else begin
                    poll_cnt = '0;
                    phase    = {GRP_RESP, k};
                    transmit(BYTE_IDLE);
                end
            end else if (phase[4:2] == GRP_RESP) begin
                if (rx == BYTE_IDLE && poll_cnt < resp_limit) begin
                    poll_cnt = poll_cnt + 1'b1;
                    transmit(BYTE_IDLE);
                end else begin
                    held_resp = rx;
                    phase     = {GRP_EXTRA, k};
                    transmit(BYTE_IDLE);
                end
            end else if (phase[4:2] == GRP_EXTRA) begin
                close_command(k);
            end else if (phase == PH_TOKEN) begin
                if (rx == BYTE_TOKEN) begin
                    phase    = PH_DATA;
                    byte_cnt = 0;
                    transmit(BYTE_IDLE);
                end else if (poll_cnt < token_limit) begin
                    poll_cnt = poll_cnt + 1'b1;
                    transmit(BYTE_IDLE);
                end else begin
                    cs_held = 1'b0;
                    conclude(ST_TOK_TMO);
                end
            end else if (phase == PH_DATA) begin
                nxt.data_valid = 1'b1;
                nxt.data_byte  = rx;
                byte_cnt++;
                if (byte_cnt >= BLOCK_BYTES) begin
                    phase    = PH_TRAIL;
                    byte_cnt = 0;
                end
                transmit(BYTE_IDLE);
            end else if (phase == PH_TRAIL) begin
                byte_cnt++;
                if (byte_cnt < TRAIL_BYTES) begin
                    transmit(BYTE_IDLE);
                end else begin
                    block_cnt++;
                    if (block_cnt < IMAGE_BLOCKS) begin
                        start_command(K_READ, cmd_arg + BLOCK_ARG);
                    end else begin
                        cs_held = 1'b0;
                        conclude(ST_OK);
                    end
                end
            end
        endfunction

        function void note_input(logic [1:0] act, logic [22:0] blk, logic [7:0] rx);
            nxt = '0;
            n_inputs++;
            case (act)
                ACT_INIT: begin
                    second_of_pair = 1'b0;
                    loop_cnt       = '0;
                    cs_held        = 1'b0;
                    phase          = PH_WAKE;
                    byte_cnt       = 1;
                    transmit(BYTE_IDLE);
                end
                ACT_READ: begin
                    block_cnt = 0;
                    start_command(K_READ, {blk, 9'd0});
                end
                ACT_BYTE: advance(rx);
                default: ;
            endcase
            nxt.chip_select   = cs_held;
            nxt.card_response = held_resp;
            if (nxt.data_valid) n_image_bytes++;
            if (nxt.done_res) n_done[nxt.status]++;
            expected_q.push_back(nxt);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            n_results++;
            compare_field("tx_byte", want.tx_byte, got.tx_byte);
            compare_field("tx_valid", want.tx_valid, got.tx_valid);
            compare_field("chip_select", want.chip_select, got.chip_select);
            compare_field("data_valid", want.data_valid, got.data_valid);
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("status", want.status, got.status);
            compare_field("card_response", want.card_response, got.card_response);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [27:0] i_cfg_data = '0;

    sd_seq_scoreboard scb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;
    bit hold_pending = 1'b0;

    sd_card_spi_init_and_image_read_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            scb.note_input(s_axis_tuser, s_axis_tdata[22:0], s_axis_tdata[30:23]);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.tx_byte       = m_axis_tdata[7:0];
            got.tx_valid      = m_axis_tdata[8];
            got.chip_select   = m_axis_tdata[9];
            got.data_byte     = m_axis_tdata[17:10];
            got.done_res      = m_axis_tdata[18];
            got.status        = m_axis_tdata[20:19];
            got.card_response = m_axis_tdata[28:21];
            got.data_valid    = m_axis_tuser;
            scb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, scb.expected_q.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic push_item(input logic [1:0] act, input logic [22:0] blk,
                             input logic [7:0] rx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, rx, blk};
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [27:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        scb.write_cfg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [27:0] resp, input logic [27:0] tok,
                             input logic [27:0] retry);
        write_reg(CFG_RESP_WAIT, resp);
        write_reg(CFG_TOKEN_WAIT, tok);
        write_reg(CFG_INIT_RETRY, retry);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (scb.expected_q.size() != 0) @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [22:0] rand_block();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return 23'($urandom);
    endfunction

    // Plays the card: answers polls and tokens according to where the sequencer stands.
    function automatic logic [7:0] card_reply(input bit clean);
        int r;
        logic [7:0] noise;
        r = $urandom_range(99);
        noise = 8'($urandom_range(255));
        if (scb.phase[4:2] == GRP_RESP) begin
            if (r < 35) return BYTE_IDLE;
            r = $urandom_range(99);
            case (scb.phase[1:0])
                K_RESET:  return (clean || r < 80) ? R1_IDLE : noise;
                K_OPCOND: begin
                    if (!clean && r >= 90) return noise;
                    return (r < 50) ? R1_READY : R1_IDLE;
                end
                K_BLKLEN: return clean ? R1_READY : noise;
                default:  return (clean || r < 85) ? R1_READY : noise;
            endcase
        end
        if (scb.phase == PH_TOKEN) begin
            if (r < 40) return BYTE_TOKEN;
            if (clean || r < 85) return BYTE_IDLE;
        end
        return noise;
    endfunction

    task automatic run_random(input int n_work);
        int n_counted;
        int r;
        logic [1:0] act;
        logic [22:0] blk;
        logic [7:0] rx;
        n_counted = 0;
        while (n_counted < n_work) begin
            r   = $urandom_range(999);
            blk = rand_block();
            rx  = 8'($urandom_range(255));
            act = ACT_BYTE;
            if (scb.phase == PH_IDLE) begin
                if (r < 450) act = ACT_INIT;
                else if (r < 900) act = ACT_READ;
                else if (r >= 960) act = ACT_UNUSED;
            end else begin
                if (r < 8) act = ACT_INIT;
                else if (r < 16) act = ACT_READ;
                else if (r < 22) act = ACT_UNUSED;
                else rx = card_reply(1'b0);
            end
            if (act != ACT_UNUSED && !(act == ACT_BYTE && scb.phase == PH_IDLE)) n_counted++;
            push_item(act, blk, rx);
        end
    endtask

    initial begin
        scb = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        configure('0, '0, '0);
        push_item(ACT_BYTE, 23'h000000, 8'hA5);
        push_item(ACT_UNUSED, 23'h7FFFFF, 8'hFF);
        push_item(ACT_INIT, 23'h2AAAAA, 8'h00);
        push_item(ACT_BYTE, 23'h555555, 8'hFF);
        // A read started mid-init aborts it; the response times out and is rejected.
        push_item(ACT_READ, 23'h000000, 8'h00);
        repeat (FRAME_BYTES) push_item(ACT_BYTE, rand_block(), 8'($urandom_range(255)));
        push_item(ACT_BYTE, 23'h000000, BYTE_IDLE);
        push_item(ACT_BYTE, 23'h000000, 8'h5A);
        // Accepted read at the top block address whose start token never comes.
        push_item(ACT_READ, 23'h7FFFFF, 8'hFF);
        repeat (FRAME_BYTES) push_item(ACT_BYTE, rand_block(), 8'($urandom_range(255)));
        push_item(ACT_BYTE, 23'h000000, R1_READY);
        push_item(ACT_BYTE, 23'h000000, 8'h00);
        push_item(ACT_BYTE, 23'h000000, 8'h12);
        drain();

        configure(28'd3, 28'd5, 28'd2);
        run_random(80);
        drain();

        send_idle_pct = 65;
        configure('0, '0, '0);
        run_random(80);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 65;
        configure(CFG_FULL_SCALE, CFG_FULL_SCALE, CFG_FULL_SCALE);
        run_random(80);
        drain();

        send_idle_pct  = 37;
        recv_stall_pct = 37;
        configure(28'($urandom_range(1, 6)), {4'hA, 24'($urandom_range(1, 12))},
                  28'($urandom_range(0, 3)));
        run_random(80);
        drain();

        // Clean init, then the first block of an image read at the top block address; the
        // command for the next block wraps the address. One long output stall hits the block.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(CFG_FULL_SCALE, CFG_FULL_SCALE, 28'(INIT_RETRY_RESET));
        push_item(ACT_INIT, rand_block(), 8'($urandom_range(255)));
        while (scb.phase != PH_IDLE) push_item(ACT_BYTE, rand_block(), card_reply(1'b1));
        push_item(ACT_READ, 23'h7FFFFF, 8'($urandom_range(255)));
        while (scb.phase != PH_IDLE && scb.block_cnt == 0) begin
            if (scb.phase == PH_DATA && scb.byte_cnt == 100) begin
                hold_pending = 1'b1;
            end
            push_item(ACT_BYTE, rand_block(), card_reply(1'b1));
        end
        repeat (FRAME_BYTES) push_item(ACT_BYTE, rand_block(), card_reply(1'b1));
        drain();

        $display("Checked %0d results from %0d input transactions, %0d of them image bytes.",
                 scb.n_results, scb.n_inputs, scb.n_image_bytes);
        $display("Operations ended: %0d ok, %0d init timeouts, %0d token timeouts, %0d rejects.",
                 scb.n_done[ST_OK], scb.n_done[ST_INIT_TMO], scb.n_done[ST_TOK_TMO],
                 scb.n_done[ST_REJECT]);
        if (scb.errors == 0 && scb.expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/sdsr_pkg.sv
hw/rtl/sdsr_step.sv
hw/rtl/sd_card_spi_init_and_image_read_top.sv
tb/tb.sv
